// File: rtl/scfd_pkg.sv
// ----------------------------------------------------------------------------
// scfd_pkg
// Shared types and constants of the stereo cross-feedback delay.
// ----------------------------------------------------------------------------
package scfd_pkg;

    // Configuration register map, one word per register
    typedef enum logic [1:0] {
        REG_DELAY     = 2'd0,
        REG_FEEDBACK  = 2'd1,
        REG_WET       = 2'd2,
        REG_PING_PONG = 2'd3
    } cfg_reg_t;

    localparam int          CFG_ADDR_BITS = 4;
    localparam int          DELAY_BITS    = 18;
    localparam int          GAIN_BITS     = 9;

    localparam logic [DELAY_BITS-1:0] DELAY_RESET = 18'd9600;
    localparam logic [GAIN_BITS-1:0]  FB_RESET    = 9'd128;
    localparam logic [GAIN_BITS-1:0]  WET_RESET   = 9'd128;

    // Gains are fractions of 256: unity, rounding half step and shift
    localparam logic [GAIN_BITS-1:0]  GAIN_UNITY  = 9'd256;
    localparam int                    GAIN_SHIFT  = 8;
    localparam int                    ROUND_HALF  = 128;

    // Control of one delay memory access cycle
    typedef struct packed {
        logic rd_en;       // issue a read at rd_addr
        logic rd_written;  // entry at rd_addr was written since reset
        logic wr_en;       // write wr_data at wr_addr
    } mem_ctl_t;

endpackage

// File: rtl/scfd_delay_mem.sv
// ----------------------------------------------------------------------------
// scfd_delay_mem
// Stereo delay memory: one write port, one registered read port, with
// forwarding of a write to the same entry in the read cycle and zero for
// entries never written since reset.
// ----------------------------------------------------------------------------
module scfd_delay_mem #(
    parameter int DEPTH = 262144,
    parameter int AW    = 18,
    parameter int DW    = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  scfd_pkg::mem_ctl_t  ctl,
    input  logic [AW-1:0]       rd_addr,
    input  logic [AW-1:0]       wr_addr,
    input  logic [DW-1:0]       wr_data,
    output logic [DW-1:0]       rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_q_reg;
    logic [DW-1:0] fwd_data_reg;
    logic          fwd_reg;
    logic          written_reg;
    logic          fwd_next;

    // Write and read the array; a read in the write cycle sees the old word
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    // Catch a write landing on the entry being read
    assign fwd_next = ctl.wr_en && (wr_addr == rd_addr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg     <= 1'b0;
            written_reg <= 1'b0;
        end
        else if (ctl.rd_en)
        begin
            fwd_reg     <= fwd_next;
            written_reg <= ctl.rd_written;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            fwd_data_reg <= wr_data;
        end
    end

    // Select forwarded word, stored word, or zero for an unwritten entry
    always_comb
    begin
        if (fwd_reg)
        begin
            rd_data = fwd_data_reg;
        end
        else if (written_reg)
        begin
            rd_data = rd_q_reg;
        end
        else
        begin
            rd_data = '0;
        end
    end

endmodule

// File: rtl/stereo_cross_feedback_delay.sv
// ----------------------------------------------------------------------------
// stereo_cross_feedback_delay
// Ping-pong delay: two delay lines sharing one write position, each fed by
// its own input plus the other channel's delayed sample times the feedback
// gain, with dry/wet mixing and an optional mono sum at the output.
//
//   channel  | signals                                   | direction
//   ---------+-------------------------------------------+----------
//   input    | in_valid, in_ready, left_in, right_in     | in
//   output   | out_valid, out_ready, left_out, right_out | out
//   config   | psel, penable, pwrite, paddr, pwdata,     | APB slave
//            | prdata, pready                            |
//
// One item per cycle sustained while the output is not stalled; from input
// accept to output valid an item passes the memory read at accept, the
// feedback/mix multiply, then round and sum into the output register.
// The single memory read and write per cycle sets the rate; a delay of one
// sample is served by forwarding the write of the previous item.
// Reset needs no clearing pass: a fill count marks entries not yet written,
// which read as zero. A stalled output holds the pipeline; input is taken
// whenever the first stage is empty or moving.
// ----------------------------------------------------------------------------
module stereo_cross_feedback_delay #(
    parameter int MAX_DELAY   = 262144,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // input items
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [SAMPLE_BITS-1:0]         left_in,
    input  logic signed [SAMPLE_BITS-1:0]         right_in,
    // output items
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [SAMPLE_BITS-1:0]         left_out,
    output logic signed [SAMPLE_BITS-1:0]         right_out,
    // configuration
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [scfd_pkg::CFG_ADDR_BITS-1:0]    paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);

    localparam int SB = SAMPLE_BITS;
    localparam int AW = $clog2(MAX_DELAY);
    localparam int NW = AW + 1;
    localparam int PW = SB + 10;
    localparam int MW = SB + 11;
    localparam int XW = SB + 12;
    localparam int GB = scfd_pkg::GAIN_BITS;

    localparam logic signed [XW-1:0] SAT_HI = XW'((1 << (SB - 1)) - 1);
    localparam logic signed [XW-1:0] SAT_LO = -SAT_HI - XW'(1);

    // Clamp a wide value to the signed sample range
    function automatic logic signed [SB-1:0] sat(input logic signed [XW-1:0] x);
        logic signed [SB-1:0] r;
        if (x > SAT_HI)
        begin
            r = SB'(SAT_HI);
        end
        else if (x < SAT_LO)
        begin
            r = SB'(SAT_LO);
        end
        else
        begin
            r = SB'(x);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [scfd_pkg::DELAY_BITS-1:0] delay_samples_reg;
    logic [GB-1:0]                   feedback_gain_reg;
    logic [GB-1:0]                   wet_mix_reg;
    logic                            ping_pong_reg;
    logic                            cfg_wr;
    scfd_pkg::cfg_reg_t              cfg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_sel = scfd_pkg::cfg_reg_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_samples_reg <= scfd_pkg::DELAY_RESET;
            feedback_gain_reg <= scfd_pkg::FB_RESET;
            wet_mix_reg       <= scfd_pkg::WET_RESET;
            ping_pong_reg     <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_sel)
                scfd_pkg::REG_DELAY:
                    delay_samples_reg <= pwdata[scfd_pkg::DELAY_BITS-1:0];
                scfd_pkg::REG_FEEDBACK:  feedback_gain_reg <= pwdata[GB-1:0];
                scfd_pkg::REG_WET:       wet_mix_reg       <= pwdata[GB-1:0];
                scfd_pkg::REG_PING_PONG: ping_pong_reg     <= pwdata[0];
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (cfg_sel)
            scfd_pkg::REG_DELAY:     prdata = 32'(delay_samples_reg);
            scfd_pkg::REG_FEEDBACK:  prdata = 32'(feedback_gain_reg);
            scfd_pkg::REG_WET:       prdata = 32'(wet_mix_reg);
            scfd_pkg::REG_PING_PONG: prdata = 32'(ping_pong_reg);
        endcase
    end

    // Clamp gains to unity; dry share is the rest of unity
    logic [GB-1:0]     fb_eff;
    logic [GB-1:0]     wet_eff;
    logic signed [9:0] fb_s;
    logic signed [9:0] wet_s;
    logic signed [9:0] dry_s;

    assign fb_eff  = (feedback_gain_reg > scfd_pkg::GAIN_UNITY) ? scfd_pkg::GAIN_UNITY
                                                               : feedback_gain_reg;
    assign wet_eff = (wet_mix_reg > scfd_pkg::GAIN_UNITY) ? scfd_pkg::GAIN_UNITY
                                                         : wet_mix_reg;
    assign fb_s    = signed'({1'b0, fb_eff});
    assign wet_s   = signed'({1'b0, wet_eff});
    assign dry_s   = signed'({1'b0, scfd_pkg::GAIN_UNITY - wet_eff});

    // ------------------------------------------------------------------
    // Pipeline handshake
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic out_valid_reg;
    logic out_free;
    logic s2_adv;
    logic s1_adv;
    logic accept;

    assign out_free  = !out_valid_reg || out_ready;
    assign s2_adv    = s2_valid_reg && out_free;
    assign s1_adv    = s1_valid_reg && (!s2_valid_reg || s2_adv);
    assign in_ready  = !s1_valid_reg || s1_adv;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (s2_adv)
            begin
                s2_valid_reg <= 1'b0;
            end
            if (s2_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: write position, fill count, read address
    // ------------------------------------------------------------------
    logic [AW-1:0] wp_reg;
    logic [AW-1:0] wp_next;
    logic [NW-1:0] fill_reg;
    logic [NW-1:0] fill_next;
    logic [NW-1:0] dly_eff;
    logic [NW-1:0] wp_ext;
    logic [NW-1:0] rd_full;
    logic [AW-1:0] rd_addr;
    logic          rd_written;

    always_comb
    begin
        if (delay_samples_reg == '0)
        begin
            dly_eff = NW'(1);
        end
        else if (32'(delay_samples_reg) > 32'(MAX_DELAY))
        begin
            dly_eff = NW'(MAX_DELAY);
        end
        else
        begin
            dly_eff = NW'(delay_samples_reg);
        end
    end

    // Step back by the delay, wrapping at the memory depth
    assign wp_ext = {1'b0, wp_reg};
    always_comb
    begin
        if (wp_ext >= dly_eff)
        begin
            rd_full = wp_ext - dly_eff;
        end
        else
        begin
            rd_full = wp_ext + NW'(MAX_DELAY) - dly_eff;
        end
    end
    assign rd_addr    = rd_full[AW-1:0];
    assign rd_written = (dly_eff <= fill_reg);

    assign wp_next   = (wp_reg == AW'(MAX_DELAY - 1)) ? '0 : wp_reg + AW'(1);
    assign fill_next = (fill_reg == NW'(MAX_DELAY)) ? fill_reg : fill_reg + NW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            fill_reg <= '0;
        end
        else if (accept)
        begin
            wp_reg   <= wp_next;
            fill_reg <= fill_next;
        end
    end

    // ------------------------------------------------------------------
    // Delay memory
    // ------------------------------------------------------------------
    scfd_pkg::mem_ctl_t    mem_ctl;
    logic [AW-1:0]         s1_wp_reg;
    logic [2*SB-1:0]       wr_data;
    logic [2*SB-1:0]       rd_data;

    assign mem_ctl.rd_en      = accept;
    assign mem_ctl.rd_written = rd_written;
    assign mem_ctl.wr_en      = s1_adv;

    scfd_delay_mem #(
        .DEPTH (MAX_DELAY),
        .AW    (AW),
        .DW    (2 * SB)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mem_ctl),
        .rd_addr (rd_addr),
        .wr_addr (s1_wp_reg),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    // ------------------------------------------------------------------
    // Stage 1: feedback write-back and dry/wet products
    // ------------------------------------------------------------------
    logic signed [SB-1:0] s1_l_in_reg;
    logic signed [SB-1:0] s1_r_in_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_l_in_reg <= left_in;
            s1_r_in_reg <= right_in;
            s1_wp_reg   <= wp_reg;
        end
    end

    logic signed [SB-1:0] l_del;
    logic signed [SB-1:0] r_del;
    logic signed [PW-1:0] l_fb_prod;
    logic signed [PW-1:0] r_fb_prod;
    logic signed [PW-1:0] l_fb_rnd;
    logic signed [PW-1:0] r_fb_rnd;
    logic signed [SB-1:0] l_wr;
    logic signed [SB-1:0] r_wr;
    logic signed [MW-1:0] l_mix_next;
    logic signed [MW-1:0] r_mix_next;

    assign l_del = signed'(rd_data[2*SB-1:SB]);
    assign r_del = signed'(rd_data[SB-1:0]);

    // Cross feedback: left takes right's delayed sample and vice versa
    assign l_fb_prod = r_del * fb_s;
    assign r_fb_prod = l_del * fb_s;
    assign l_fb_rnd  = (l_fb_prod + PW'(scfd_pkg::ROUND_HALF)) >>> scfd_pkg::GAIN_SHIFT;
    assign r_fb_rnd  = (r_fb_prod + PW'(scfd_pkg::ROUND_HALF)) >>> scfd_pkg::GAIN_SHIFT;
    assign l_wr      = sat(XW'(s1_l_in_reg) + XW'(l_fb_rnd));
    assign r_wr      = sat(XW'(s1_r_in_reg) + XW'(r_fb_rnd));
    assign wr_data   = {l_wr, r_wr};

    // Full-precision dry/wet sums, rounded in the next stage
    assign l_mix_next = MW'(s1_l_in_reg * dry_s) + MW'(l_del * wet_s);
    assign r_mix_next = MW'(s1_r_in_reg * dry_s) + MW'(r_del * wet_s);

    logic signed [MW-1:0] s2_l_mix_reg;
    logic signed [MW-1:0] s2_r_mix_reg;

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_l_mix_reg <= l_mix_next;
            s2_r_mix_reg <= r_mix_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: round, saturate, optional mono sum
    // ------------------------------------------------------------------
    logic signed [MW-1:0] l_mix_rnd;
    logic signed [MW-1:0] r_mix_rnd;
    logic signed [SB-1:0] l_mix_sat;
    logic signed [SB-1:0] r_mix_sat;
    logic signed [SB-1:0] mono;
    logic signed [SB-1:0] left_out_next;
    logic signed [SB-1:0] right_out_next;
    logic signed [SB-1:0] left_out_reg;
    logic signed [SB-1:0] right_out_reg;

    assign l_mix_rnd = (s2_l_mix_reg + MW'(scfd_pkg::ROUND_HALF)) >>> scfd_pkg::GAIN_SHIFT;
    assign r_mix_rnd = (s2_r_mix_reg + MW'(scfd_pkg::ROUND_HALF)) >>> scfd_pkg::GAIN_SHIFT;
    assign l_mix_sat = sat(XW'(l_mix_rnd));
    assign r_mix_sat = sat(XW'(r_mix_rnd));
    assign mono      = sat(XW'(l_mix_sat) + XW'(r_mix_sat));

    assign left_out_next  = ping_pong_reg ? l_mix_sat : mono;
    assign right_out_next = ping_pong_reg ? r_mix_sat : mono;

    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            left_out_reg  <= left_out_next;
            right_out_reg <= right_out_next;
        end
    end

    assign left_out  = left_out_reg;
    assign right_out = right_out_reg;

endmodule
